### rtl/core/uvlt_pkg.sv
// unsorted value list table: shared package
// item and result structs, operation and status codes, default sizes
// no dependencies
`default_nettype none

package uvlt_pkg;

  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned KIND_W    = 3;
  localparam int unsigned VAL_IN_W  = 32;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RST_CUR = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_END       = 2'd3
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [VAL_IN_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [IDX_OUT_W-1:0]     index;
    logic signed [DATA_W-1:0] data;
    logic [CNT_OUT_W-1:0]     count;
    logic                     full_res;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/unsorted_value_list_table.sv
// channel  | handshake           | payload | notes
// request  | start / busy        | req_i   | taken when start high and busy low
// result   | done_o (strobe)     | res_o   | valid for one cycle, no back pressure
//
// insert, clear, reset cursor and unused kinds: result in the cycle after the item,
// next item may follow at once. read next: ram read, then busy in ST_READ, then result;
// past the end of the list the result comes in the cycle after the item.
// search: one ram read per held entry; result on a match or after the last entry.
// delete: scan as search, then a prime step and one ram write per entry ahead of
// the match; result with the last write, or at once for a match at the front.
// reset clears state, strobe, count and cursor; ram contents need no clearing pass.
`default_nettype none

module unsorted_value_list_table
  import uvlt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;

  uvlt_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  uvlt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

### rtl/core/uvlt_ram.sv
// unsorted value list table: generic single-port-write ram
// one write port, one read port, registered read data
// no dependencies
`default_nettype none

module uvlt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/uvlt_ctrl.sv
// unsorted value list table: operation sequencer
// keeps count and cursor, scans and shifts the entry ram, builds results
// depends on uvlt_pkg; drives one uvlt_ram instance in the top level
`default_nettype none

module uvlt_ctrl
  import uvlt_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire req_t                  req_i,
  output logic                       done_o,
  output res_t                       res_o,
  output logic                       ram_we_o,
  output logic [AW-1:0]              ram_waddr_o,
  output logic [VALUE_BITS-1:0]      ram_wdata_o,
  output logic [AW-1:0]              ram_raddr_o,
  input  wire logic [VALUE_BITS-1:0] ram_rdata_i
);

  // entries live in reverse order: front of the list is ram[count-1]
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_PRIME,
    ST_SHIFT
  } state_e;

  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

  state_e                  state_q, state_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           cursor_q, cursor_d;
  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [VALUE_BITS-1:0]   val_q, val_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           ptr_q, ptr_d;
  logic                    done_q, done_d;
  res_t                    res_q, res_d;

  logic [VAL_IN_W-1:0]     value_raw;
  logic [VALUE_BITS-1:0]   v_in;
  logic                    del_fin;

  assign value_raw = req_i.value;
  assign v_in      = VALUE_BITS'(value_raw);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    kind_d   = kind_q;
    val_d    = val_q;
    idx_d    = idx_q;
    ptr_d    = ptr_q;
    done_d   = 1'b0;
    res_d    = res_q;
    del_fin  = 1'b0;

    ram_we_o    = 1'b0;
    ram_waddr_o = AW'(count_q);
    ram_wdata_o = v_in;
    ram_raddr_o = AW'(count_q - CW'(1) - cursor_q);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          kind_d       = req_i.kind;
          val_d        = v_in;
          idx_d        = '0;
          res_d.status = STAT_OK;
          res_d.index  = '0;
          res_d.data   = '0;
          unique case (req_i.kind) inside
            KIND_INSERT: begin
              done_d = 1'b1;
              if (count_q == CNT_CAP) begin
                res_d.status = STAT_FULL;
              end else begin
                ram_we_o = 1'b1;
                count_d  = count_q + CW'(1);
                if (cursor_q < count_d) begin
                  cursor_d = cursor_q + CW'(1);
                end
              end
            end
            KIND_DELETE, KIND_SEARCH: begin
              ram_raddr_o = AW'(count_q - CW'(1));
              if (count_q == '0) begin
                res_d.status = STAT_NOT_FOUND;
                done_d       = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            KIND_CLEAR: begin
              count_d  = '0;
              cursor_d = '0;
              done_d   = 1'b1;
            end
            KIND_RST_CUR: begin
              cursor_d = '0;
              done_d   = 1'b1;
            end
            KIND_READ: begin
              if (cursor_q >= count_q) begin
                res_d.status = STAT_END;
                done_d       = 1'b1;
              end else begin
                state_d = ST_READ;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        res_d.status = STAT_OK;
        res_d.index  = IDX_OUT_W'(cursor_q);
        res_d.data   = DATA_W'(ram_rdata_i);
        cursor_d     = cursor_q + CW'(1);
        done_d       = 1'b1;
        state_d      = ST_IDLE;
      end

      ST_SCAN: begin
        ram_raddr_o = AW'(count_q - CW'(2) - CW'(idx_q));
        if (ram_rdata_i == val_q) begin
          if (kind_q == KIND_SEARCH) begin
            res_d.status = STAT_OK;
            res_d.index  = IDX_OUT_W'(idx_q);
            done_d       = 1'b1;
            state_d      = ST_IDLE;
          end else if (idx_q == '0) begin
            del_fin = 1'b1;
          end else begin
            ptr_d   = AW'(count_q - CW'(1) - CW'(idx_q));
            state_d = ST_PRIME;
          end
        end else if (CW'(idx_q) == count_q - CW'(1)) begin
          res_d.status = STAT_NOT_FOUND;
          res_d.index  = '0;
          done_d       = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      ST_PRIME: begin
        ram_raddr_o = AW'(CW'(ptr_q) + CW'(1));
        state_d     = ST_SHIFT;
      end

      ST_SHIFT: begin
        // close the gap: ram[ptr] takes ram[ptr+1]
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = ram_rdata_i;
        ram_raddr_o = AW'(CW'(ptr_q) + CW'(2));
        ptr_d       = ptr_q + AW'(1);
        if (CW'(ptr_q) == count_q - CW'(2)) begin
          del_fin = 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (del_fin) begin
      count_d = count_q - CW'(1);
      if (cursor_q > CW'(idx_q)) begin
        cursor_d = cursor_q - CW'(1);
      end
      res_d.status = STAT_OK;
      res_d.index  = IDX_OUT_W'(idx_q);
      done_d       = 1'b1;
      state_d      = ST_IDLE;
    end

    res_d.count    = CNT_OUT_W'(count_d);
    res_d.full_res = (count_d == CNT_CAP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    val_q  <= val_d;
    idx_q  <= idx_d;
    ptr_q  <= ptr_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef ASSERT_OFF
  a_cursor_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("read cursor beyond entry count");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_CAP)
    else $error("entry count beyond capacity");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_item_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_q || busy))
    else $error("accepted item neither answered nor in progress");

  a_shift_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> ((CW'(ptr_q) + CW'(2)) <= count_q))
    else $error("shift write outside held entries");
`endif

endmodule

`default_nettype wire

### test/list_table_checker.sv
// result checker for the unsorted value list table
// predicts every result from the accepted items and compares it field by field
// depends on uvlt_pkg for the item and result structs and the codes
`timescale 1ns / 1ps

module list_table_checker
  import uvlt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  input  wire logic busy,
  input  wire req_t req_i,
  input  wire logic done_o,
  input  wire res_t res_o,
  output int        fail_count_o,
  output int        pending_o
);

  logic signed [DATA_W-1:0] vals [CAPACITY_DEF];
  int   held;
  int   cursor;
  int   fails;
  res_t expected_results [$];

  function automatic res_t apply_list_op(input req_t r);
    res_t o;
    int   pos;
    int   i;
    o   = '0;
    pos = -1;
    if (r.kind == KIND_DELETE || r.kind == KIND_SEARCH) begin
      for (i = 0; i < held; i++) begin
        if (pos < 0 && vals[i] == r.value) pos = i;
      end
    end
    case (r.kind)
      KIND_INSERT: begin
        if (held >= CAPACITY_DEF) begin
          o.status = STAT_FULL;
        end else begin
          for (i = held; i > 0; i--) vals[i] = vals[i-1];
          vals[0] = r.value;
          held++;
          if (cursor < held) cursor++;
        end
      end
      KIND_DELETE: begin
        if (pos < 0) begin
          o.status = STAT_NOT_FOUND;
        end else begin
          for (i = pos; i < held - 1; i++) vals[i] = vals[i+1];
          held--;
          if (cursor > pos) cursor--;
          o.index = IDX_OUT_W'(pos);
        end
      end
      KIND_SEARCH: begin
        if (pos < 0) o.status = STAT_NOT_FOUND;
        else o.index = IDX_OUT_W'(pos);
      end
      KIND_CLEAR: begin
        held   = 0;
        cursor = 0;
      end
      KIND_RST_CUR: begin
        cursor = 0;
      end
      KIND_READ: begin
        if (cursor >= held) begin
          o.status = STAT_END;
        end else begin
          o.data  = vals[cursor];
          o.index = IDX_OUT_W'(cursor);
          cursor++;
        end
      end
      default: begin
      end
    endcase
    o.count    = CNT_OUT_W'(held);
    o.full_res = (held == CAPACITY_DEF);
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      held   = 0;
      cursor = 0;
      expected_results.delete();
    end else begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no item pending, expected none, got %0h", $time, res_o);
          fails++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", 32'(e.status), 32'(res_o.status));
          check_field("index", 32'(e.index), 32'(res_o.index));
          check_field("data", e.data, res_o.data);
          check_field("count", 32'(e.count), 32'(res_o.count));
          check_field("full_res", 32'(e.full_res), 32'(res_o.full_res));
        end
      end
      if (start && !busy) expected_results.push_back(apply_list_op(req_i));
      fail_count_o <= fails;
      pending_o    <= expected_results.size();
    end
  end

endmodule

### test/unsorted_value_list_table_test.sv
// top of the unsorted value list table test: clock, reset, item stimulus, verdict
// directed list walks first, then random fill, mixed and clear phases in bursts
// depends on uvlt_pkg, unsorted_value_list_table and list_table_checker
`timescale 1ns / 1ps

module unsorted_value_list_table_test;
  import uvlt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int ITEM_TARGET = 1700;
  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam logic signed [VAL_IN_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_IN_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  req_t req_i  = '0;
  logic busy;
  logic done_o;
  res_t res_o;
  int   fail_count;
  int   pending_count;
  int   cycles = 0;
  int   items_sent = 0;
  int   burst_left = 0;
  logic signed [VAL_IN_W-1:0] pool [8];

  always #2 clk_i = ~clk_i;

  unsorted_value_list_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  list_table_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_i        (req_i),
    .done_o       (done_o),
    .res_o        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [KIND_W-1:0] k, input logic signed [VAL_IN_W-1:0] v);
    req_t r;
    r.kind  = k;
    r.value = v;
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      if ($urandom_range(4, 0) == 0) burst_left = $urandom_range(150, 40);
      else burst_left = $urandom_range(20, 0);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic new_pool();
    int i;
    for (i = 0; i < 8; i++) begin
      case ($urandom_range(9, 0))
        0:       pool[i] = VAL_MIN;
        1:       pool[i] = VAL_MAX;
        2:       pool[i] = '0;
        3:       pool[i] = -1;
        default: pool[i] = $urandom;
      endcase
    end
  endtask

  function automatic logic signed [VAL_IN_W-1:0] pick_value();
    if ($urandom_range(9, 0) < 8) return pool[$urandom_range(7, 0)];
    return $urandom;
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int w;
    w = $urandom_range(99, 0);
    if (w < 30) return KIND_INSERT;
    if (w < 50) return KIND_DELETE;
    if (w < 70) return KIND_SEARCH;
    if (w < 92) return KIND_READ;
    if (w < 96) return KIND_RST_CUR;
    if (w < 98) return KIND_CLEAR;
    if (w < 99) return KIND_SPARE_A;
    return KIND_SPARE_B;
  endfunction

  task automatic fill_phase();
    logic signed [VAL_IN_W-1:0] marker;
    int i;
    marker = $urandom;
    send_item(KIND_INSERT, marker);
    for (i = 0; i < 70; i++) send_item(KIND_INSERT, pick_value());
    send_item(KIND_SEARCH, marker);
    send_item(KIND_RST_CUR, $urandom);
    for (i = 0; i < 67; i++) send_item(KIND_READ, $urandom);
    for (i = 0; i < 20; i++) begin
      case ($urandom_range(3, 0))
        0:       send_item(KIND_DELETE, marker);
        1:       send_item(KIND_READ, $urandom);
        2:       send_item(KIND_SEARCH, pick_value());
        default: send_item(KIND_DELETE, pick_value());
      endcase
    end
  endtask

  task automatic mixed_phase();
    int i;
    for (i = 0; i < 40; i++) send_item(pick_kind(), pick_value());
  endtask

  initial begin
    int phase;
    new_pool();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk over the list edges and cursor moves
    send_item(KIND_READ, '0);
    send_item(KIND_SEARCH, 32'sd5);
    send_item(KIND_DELETE, 32'sd5);
    send_item(KIND_INSERT, VAL_MIN);
    send_item(KIND_INSERT, VAL_MAX);
    send_item(KIND_INSERT, '0);
    send_item(KIND_INSERT, -1);
    send_item(KIND_SEARCH, VAL_MIN);
    send_item(KIND_SEARCH, -1);
    send_item(KIND_READ, VAL_MAX);
    send_item(KIND_READ, '0);
    send_item(KIND_INSERT, 32'sd7);
    send_item(KIND_READ, '0);
    send_item(KIND_DELETE, 32'sd7);
    send_item(KIND_READ, '0);
    send_item(KIND_READ, '0);
    send_item(KIND_RST_CUR, VAL_MIN);
    send_item(KIND_READ, '0);
    send_item(KIND_DELETE, -1);
    send_item(KIND_DELETE, '0);
    send_item(KIND_READ, '0);
    send_item(KIND_SPARE_A, $urandom);
    send_item(KIND_SPARE_B, $urandom);
    send_item(KIND_SEARCH, 32'sd12345);
    send_item(KIND_CLEAR, -1);
    send_item(KIND_READ, '0);
    settle();

    while (items_sent < ITEM_TARGET) begin
      phase = $urandom_range(9, 0);
      if (phase < 3) fill_phase();
      else if (phase < 9) mixed_phase();
      else send_item(KIND_CLEAR, pick_value());
      if ($urandom_range(7, 0) == 0) settle();
      if ($urandom_range(3, 0) == 0) new_pool();
    end

    settle();
    repeat (CAPACITY_DEF + 8) @(posedge clk_i);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
